@@ rtl/mspp_pkg.sv @@
// ----------------------------------------------------------------------------
// MSP v1 frame parser package
// Shared constants and types for the frame parser and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package mspp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [KindW-1:0] kind_t;

  localparam byte_t HdrStart = 8'h24;
  localparam byte_t HdrMagic = 8'h4D;

  localparam kind_t KindPayload = 2'd0;
  localparam kind_t KindGood    = 2'd1;
  localparam kind_t KindBad     = 2'd2;

  typedef enum logic [6:0] {
    PhHunt  = 7'b000_0001,
    PhMagic = 7'b000_0010,
    PhDir   = 7'b000_0100,
    PhLen   = 7'b000_1000,
    PhCmd   = 7'b001_0000,
    PhData  = 7'b010_0000,
    PhChk   = 7'b100_0000
  } phase_e;

  typedef struct packed {
    kind_t result_kind;
    byte_t frame_direction;
    byte_t frame_command;
    byte_t frame_length;
    byte_t payload_data;
    byte_t payload_index;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/mspp_if.sv @@
// ----------------------------------------------------------------------------
// MSP v1 frame parser channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mspp_byte_if;
  logic             valid;
  logic             ready;
  mspp_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mspp_result_if;
  logic             valid;
  logic             ready;
  mspp_pkg::kind_t  result_kind;
  mspp_pkg::byte_t  frame_direction;
  mspp_pkg::byte_t  frame_command;
  mspp_pkg::byte_t  frame_length;
  mspp_pkg::byte_t  payload_data;
  mspp_pkg::byte_t  payload_index;

  modport source (output valid, output result_kind, output frame_direction,
                  output frame_command, output frame_length, output payload_data,
                  output payload_index, input ready);
  modport sink   (input valid, input result_kind, input frame_direction,
                  input frame_command, input frame_length, input payload_data,
                  input payload_index, output ready);
endinterface

`default_nettype wire

@@ rtl/msp_v1_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// MSP v1 frame parser unit
// Follows MSP v1 frames byte by byte and reports each payload word and the
// checksum verdict at the end of each frame.
// ----------------------------------------------------------------------------
// A result passes through the input register and then the result register
// before it is presented.
// Throughput: one word per cycle, sustained while the result side takes results.
// Reset: asynchronous, active low; the parser hunts for a header start and all
// held frame fields and the checksum are cleared.
`default_nettype none

module msp_v1_frame_parser_unit (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mspp_byte_if.sink    rx_i,
  mspp_result_if.source res_o
);
  import mspp_pkg::*;

  logic    in_valid_q;
  byte_t   in_byte_q;
  phase_e  phase_q, phase_d;
  byte_t   dir_q, dir_d;
  byte_t   len_q, len_d;
  byte_t   cmd_q, cmd_d;
  byte_t   cnt_q, cnt_d;
  byte_t   xor_q, xor_d;
  logic    out_valid_q;
  result_t res_q, res_d;
  logic    has_result;
  logic    out_free;
  logic    proc;

  assign out_free = !out_valid_q || res_o.ready;
  assign proc     = in_valid_q && (!has_result || out_free);
  assign rx_i.ready = !in_valid_q || proc;

  always_comb begin
    phase_d    = phase_q;
    dir_d      = dir_q;
    len_d      = len_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    xor_d      = xor_q;
    has_result = 1'b0;
    res_d.result_kind     = KindPayload;
    res_d.frame_direction = dir_q;
    res_d.frame_command   = cmd_q;
    res_d.frame_length    = len_q;
    res_d.payload_data    = '0;
    res_d.payload_index   = '0;
    unique case (phase_q)
      PhMagic: begin
        phase_d = (in_byte_q == HdrMagic) ? PhDir : PhHunt;
      end
      PhDir: begin
        dir_d   = in_byte_q;
        phase_d = PhLen;
      end
      PhLen: begin
        len_d   = in_byte_q;
        cnt_d   = '0;
        xor_d   = in_byte_q;
        phase_d = PhCmd;
      end
      PhCmd: begin
        cmd_d   = in_byte_q;
        xor_d   = xor_q ^ in_byte_q;
        phase_d = (len_q == '0) ? PhChk : PhData;
      end
      PhData: begin
        xor_d      = xor_q ^ in_byte_q;
        cnt_d      = cnt_q + 8'd1;
        if (cnt_d == len_q) begin
          phase_d = PhChk;
        end
        has_result          = 1'b1;
        res_d.payload_data  = in_byte_q;
        res_d.payload_index = cnt_q;
      end
      PhChk: begin
        phase_d           = PhHunt;
        has_result        = 1'b1;
        res_d.result_kind = (in_byte_q == xor_q) ? KindGood : KindBad;
      end
      default: begin
        phase_d = (in_byte_q == HdrStart) ? PhMagic : PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhHunt;
      dir_q       <= '0;
      len_q       <= '0;
      cmd_q       <= '0;
      cnt_q       <= '0;
      xor_q       <= '0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (proc) begin
        phase_q <= phase_d;
        dir_q   <= dir_d;
        len_q   <= len_d;
        cmd_q   <= cmd_d;
        cnt_q   <= cnt_d;
        xor_q   <= xor_d;
      end
      if (out_free) begin
        out_valid_q <= proc && has_result;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (proc && has_result) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.result_kind     = res_q.result_kind;
  assign res_o.frame_direction = res_q.frame_direction;
  assign res_o.frame_command   = res_q.frame_command;
  assign res_o.frame_length    = res_q.frame_length;
  assign res_o.payload_data    = res_q.payload_data;
  assign res_o.payload_index   = res_q.payload_index;

  // The payload count stays below the declared length while payload is expected.
  a_cnt_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (cnt_q < len_q))
    else $error("payload count reached declared length in payload phase");

  // A held word that cannot be processed must not be overwritten.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input word lost");

  // A checksum word always produces a result.
  a_chk_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && phase_q == PhChk) |=> (out_valid_q && phase_q == PhHunt))
    else $error("checksum word gave no result");

  // A zero-length frame goes straight from the command to the checksum.
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && phase_q == PhCmd && len_q == '0) |=> (phase_q == PhChk))
    else $error("zero-length frame did not skip the payload");

endmodule

`default_nettype wire

@@ tb/sv/msp_v1_frame_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MSP v1 frame parser unit testbench
// Feeds the parser received words: a short table of header faults, a
// zero-length frame and a frame with a bad checksum, followed by random
// frames, noise and broken headers. Both channels idle at random. Every
// result is compared field by field against the table's expected value or
// against a behavioural parser that follows the accepted input words.
// ----------------------------------------------------------------------------

module msp_v1_frame_parser_unit_tb;
  import mspp_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int RxTarget   = 650;

  typedef struct packed {
    byte_t   rx_byte;
    logic    typed;
    result_t want;
  } stim_row_t;

  localparam result_t NoRes = '0;
  localparam result_t ZeroLenGood = '{KindGood, 8'h3C, 8'hFF, 8'h00, 8'h00, 8'h00};
  localparam result_t LenTwoWord0 = '{KindPayload, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00};
  localparam result_t LenTwoWord1 = '{KindPayload, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h01};
  localparam result_t LenTwoBad   = '{KindBad, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h00};

  localparam int NumRows = 21;
  localparam stim_row_t StimTable [NumRows] = '{
    '{8'h00,    1'b0, NoRes},
    '{8'hFF,    1'b0, NoRes},
    '{HdrStart, 1'b0, NoRes},
    '{8'h58,    1'b0, NoRes},
    '{HdrStart, 1'b0, NoRes},
    '{HdrStart, 1'b0, NoRes},
    '{HdrMagic, 1'b0, NoRes},
    '{HdrStart, 1'b0, NoRes},
    '{HdrMagic, 1'b0, NoRes},
    '{8'h3C,    1'b0, NoRes},
    '{8'h00,    1'b0, NoRes},
    '{8'hFF,    1'b0, NoRes},
    '{8'hFF,    1'b1, ZeroLenGood},
    '{HdrStart, 1'b0, NoRes},
    '{HdrMagic, 1'b0, NoRes},
    '{8'hFF,    1'b0, NoRes},
    '{8'h02,    1'b0, NoRes},
    '{8'h00,    1'b0, NoRes},
    '{8'hFF,    1'b1, LenTwoWord0},
    '{8'h00,    1'b1, LenTwoWord1},
    '{8'h00,    1'b1, LenTwoBad}
  };

  logic clk_i;
  logic rst_ni;

  mspp_byte_if   rx_if ();
  mspp_result_if res_if ();

  msp_v1_frame_parser_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  phase_e  frame_phase   = PhHunt;
  byte_t   dir_held      = '0;
  byte_t   len_held      = '0;
  byte_t   cmd_held      = '0;
  byte_t   payload_count = '0;
  byte_t   xor_acc       = '0;
  result_t parse_results_due [$];
  int      mismatches    = 0;
  int      words_sent    = 0;
  int      rx_burst      = 0;
  int      res_burst     = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic parse_rx_byte(input byte_t b, output result_t r);
    r = NoRes;
    case (frame_phase)
      PhMagic: begin
        frame_phase = (b == HdrMagic) ? PhDir : PhHunt;
        return 1'b0;
      end
      PhDir: begin
        dir_held    = b;
        frame_phase = PhLen;
        return 1'b0;
      end
      PhLen: begin
        len_held      = b;
        payload_count = '0;
        xor_acc       = b;
        frame_phase   = PhCmd;
        return 1'b0;
      end
      PhCmd: begin
        cmd_held    = b;
        xor_acc     = xor_acc ^ b;
        frame_phase = (len_held == 8'd0) ? PhChk : PhData;
        return 1'b0;
      end
      PhData: begin
        r = '{KindPayload, dir_held, cmd_held, len_held, b, payload_count};
        xor_acc       = xor_acc ^ b;
        payload_count = payload_count + 8'd1;
        if (payload_count == len_held) frame_phase = PhChk;
        return 1'b1;
      end
      PhChk: begin
        r = '{(b == xor_acc) ? KindGood : KindBad, dir_held, cmd_held, len_held,
              8'h00, 8'h00};
        frame_phase = PhHunt;
        return 1'b1;
      end
      default: begin
        frame_phase = (b == HdrStart) ? PhMagic : PhHunt;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic send_word(input byte_t b, input logic typed, input result_t want);
    int      gap;
    logic    got;
    result_t r;
    gap = draw_gap(rx_burst);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    got = parse_rx_byte(b, r);
    if (typed) parse_results_due = {parse_results_due, want};
    else if (got) parse_results_due = {parse_results_due, r};
    words_sent++;
  endtask

  initial begin
    byte_t frame_len;
    byte_t frame_xor;
    byte_t b;
    int    choice;
    int    n;
    logic  long_done;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    long_done     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_word(StimTable[i].rx_byte, StimTable[i].typed, StimTable[i].want);
    end

    while (words_sent < RxTarget) begin
      choice = $urandom_range(0, 99);
      if (choice < 10) begin
        n = $urandom_range(1, 4);
        repeat (n) send_word(byte_t'($urandom), 1'b0, NoRes);
      end else if (choice < 18) begin
        send_word(HdrStart, 1'b0, NoRes);
        do b = byte_t'($urandom); while (b == HdrMagic);
        send_word(b, 1'b0, NoRes);
      end else begin
        if (!long_done && (words_sent > 300 || $urandom_range(0, 39) == 0)) begin
          frame_len = 8'hFF;
          long_done = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          frame_len = 8'h00;
        end else begin
          frame_len = byte_t'($urandom_range(1, 12));
        end
        send_word(HdrStart, 1'b0, NoRes);
        send_word(HdrMagic, 1'b0, NoRes);
        send_word(byte_t'($urandom), 1'b0, NoRes);
        send_word(frame_len, 1'b0, NoRes);
        b = byte_t'($urandom);
        frame_xor = frame_len ^ b;
        send_word(b, 1'b0, NoRes);
        for (int i = 0; i < int'(frame_len); i++) begin
          b = byte_t'($urandom);
          frame_xor = frame_xor ^ b;
          send_word(b, 1'b0, NoRes);
        end
        if ($urandom_range(0, 3) == 0) frame_xor = frame_xor ^ byte_t'($urandom_range(1, 255));
        send_word(frame_xor, 1'b0, NoRes);
      end
    end
    rx_if.valid <= 1'b0;

    while (parse_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int      gap;
    result_t want;
    res_if.ready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = draw_gap(res_burst);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (parse_results_due.size() == 0) begin
        $error("result with none outstanding: kind %0d, data %0h",
               res_if.result_kind, res_if.payload_data);
        mismatches++;
      end else begin
        want = parse_results_due.pop_front();
        if (res_if.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, actual %0d", want.result_kind,
                 res_if.result_kind);
          mismatches++;
        end
        if (res_if.frame_direction !== want.frame_direction) begin
          $error("frame_direction: expected %0h, actual %0h", want.frame_direction,
                 res_if.frame_direction);
          mismatches++;
        end
        if (res_if.frame_command !== want.frame_command) begin
          $error("frame_command: expected %0h, actual %0h", want.frame_command,
                 res_if.frame_command);
          mismatches++;
        end
        if (res_if.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, actual %0d", want.frame_length,
                 res_if.frame_length);
          mismatches++;
        end
        if (res_if.payload_data !== want.payload_data) begin
          $error("payload_data: expected %0h, actual %0h", want.payload_data,
                 res_if.payload_data);
          mismatches++;
        end
        if (res_if.payload_index !== want.payload_index) begin
          $error("payload_index: expected %0d, actual %0d", want.payload_index,
                 res_if.payload_index);
          mismatches++;
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
